### src/fvn_pkg.sv
// ----------------------------------------------------------------------------
// fvn_pkg
// Types, constants and arithmetic helpers for the 3D fractal value noise.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int OCTAVES    = 4;
    localparam int OCT_W      = 3;
    localparam int COORD_W    = 32;
    localparam int CRD_W      = 48;
    localparam int SUM_W      = 17;
    localparam int VAL_W      = 16;
    localparam int SIDE_DEPTH = 9;

    localparam logic [SUM_W-1:0] SUM_MAX = 17'h1ffff;

    localparam logic [31:0] HASH_MUL_A = 32'd57;
    localparam logic [31:0] HASH_MUL_B = 32'd113;
    localparam logic [31:0] HASH_SQ    = 32'd15731;
    localparam logic [31:0] HASH_LIN   = 32'd789221;
    localparam logic [31:0] HASH_OFS   = 32'd1376312589;
    localparam logic [17:0] EASE_THREE = 18'd196608;

    // corner offsets: x adds 1, y adds 57, z adds 113
    localparam logic [7:0][31:0] CORNER_OFF = {
        32'd171, 32'd58, 32'd114, 32'd1, 32'd170, 32'd57, 32'd113, 32'd0
    };

    typedef struct packed {
        logic [2:0][CRD_W-1:0] crd;
        logic [SUM_W-1:0]      sum;
    } t_side;

    function automatic logic [VAL_W-1:0] blend(
        input logic [VAL_W-1:0] a,
        input logic [VAL_W-1:0] b,
        input logic [VAL_W-1:0] t
    );
        logic [32:0] acc;
        acc = 33'(a) * 33'(17'h10000 - {1'b0, t}) + 33'(b) * 33'(t);
        return acc[31:16];
    endfunction

endpackage

### src/fvn_if.sv
// ----------------------------------------------------------------------------
// fvn_if
// Point and noise channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fvn_in_if;
    import fvn_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

interface fvn_out_if;
    import fvn_pkg::*;
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] noise_sum;
    modport source (output valid, output noise_sum, input ready);
    modport sink   (input valid, input noise_sum, output ready);
endinterface

### src/fvn_cell.sv
// ----------------------------------------------------------------------------
// fvn_cell
// One octave: lattice hash, smoothstep, trilinear blend and accumulate.
// ----------------------------------------------------------------------------
module fvn_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [2:0]           i_octave,
    input  logic                 i_vld,
    input  fvn_pkg::t_side       i_side,
    output logic                 o_vld,
    output fvn_pkg::t_side       o_side
);
    import fvn_pkg::*;

    logic [SIDE_DEPTH:0]         r_vld;
    t_side                       r_side [SIDE_DEPTH];
    logic [31:0]                 r_b;
    logic [2:0][31:0]            r_ff;
    logic [2:0][15:0]            r_f;
    logic [7:0][31:0]            r_n;
    logic [2:0][15:0]            r_f2;
    logic [2:0][17:0]            r_k;
    logic [7:0][31:0]            r_sq;
    logic [7:0][31:0]            r_n3;
    logic [7:0][31:0]            r_p;
    logic [7:0][31:0]            r_n4;
    logic [7:0][31:0]            r_q;
    logic [7:0][VAL_W-1:0]       r_v;
    logic [3:0][VAL_W-1:0]       r_cx;
    logic [1:0][VAL_W-1:0]       r_cy;
    logic [VAL_W-1:0]            r_oct;
    logic [2:0][VAL_W-1:0]       r_t [3:8];
    t_side                       r_out;

    logic [2:0][31:0]            n_ip;
    logic [2:0][15:0]            n_f;
    logic [7:0][31:0]            n_n;
    logic [7:0][31:0]            n_h;
    logic [2:0][33:0]            n_ease;
    logic [17:0]                 n_add;
    t_side                       n_out;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_ip[a] = i_side.crd[a][47:16];
            n_f[a]  = i_side.crd[a][15:0];
        end
        for (int j = 0; j < 8; j++) begin
            n_n[j] = r_b + CORNER_OFF[j];
            n_n[j] = (n_n[j] << 13) ^ n_n[j];
            n_h[j] = r_q[j] + HASH_OFS;
        end
        for (int a = 0; a < 3; a++) begin
            n_ease[a] = 34'(r_f2[a]) * 34'(r_k[a]);
        end
        n_add = {1'b0, r_side[SIDE_DEPTH-1].sum} + 18'(r_oct >> i_octave);
        for (int a = 0; a < 3; a++) begin
            n_out.crd[a] = r_side[SIDE_DEPTH-1].crd[a] << 1;
        end
        n_out.sum = n_add[17] ? SUM_MAX : n_add[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SIDE_DEPTH-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < SIDE_DEPTH; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_b <= n_ip[0] + 32'(n_ip[1] * HASH_MUL_A) + 32'(n_ip[2] * HASH_MUL_B);
            for (int a = 0; a < 3; a++) begin
                r_ff[a] <= 32'(n_f[a]) * 32'(n_f[a]);
                r_f[a]  <= n_f[a];
                r_f2[a] <= r_ff[a][31:16];
                r_k[a]  <= EASE_THREE - {1'b0, r_f[a], 1'b0};
                r_t[3][a] <= n_ease[a][31:16];
            end
            for (int s = 4; s <= 8; s++) begin
                r_t[s] <= r_t[s-1];
            end
            for (int j = 0; j < 8; j++) begin
                r_n[j]  <= n_n[j];
                r_sq[j] <= r_n[j] * r_n[j];
                r_n3[j] <= r_n[j];
                r_p[j]  <= 32'(r_sq[j] * HASH_SQ) + HASH_LIN;
                r_n4[j] <= r_n3[j];
                r_q[j]  <= r_n4[j] * r_p[j];
                r_v[j]  <= n_h[j][30:15];
            end
            for (int j = 0; j < 4; j++) begin
                r_cx[j] <= blend(r_v[j], r_v[j+4], r_t[6][0]);
            end
            r_cy[0] <= blend(r_cx[0], r_cx[2], r_t[7][1]);
            r_cy[1] <= blend(r_cx[1], r_cx[3], r_t[7][1]);
            r_oct   <= blend(r_cy[0], r_cy[1], r_t[8][2]);
            r_out   <= n_out;
        end
    end

    assign o_vld  = r_vld[SIDE_DEPTH];
    assign o_side = r_out;

endmodule

### src/fvn_skid.sv
// ----------------------------------------------------------------------------
// fvn_skid
// Two-entry output buffer; holds results while the sink stalls.
// ----------------------------------------------------------------------------
module fvn_skid (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [fvn_pkg::SUM_W-1:0]   i_data,
    output logic                        o_en,
    output logic                        o_vld,
    input  logic                        i_ready,
    output logic [fvn_pkg::SUM_W-1:0]   o_data
);
    import fvn_pkg::*;

    logic [SUM_W-1:0] r_buf [2];
    logic [1:0]       r_cnt;
    logic             r_rd;
    logic             r_wr;
    logic             n_push;
    logic             n_pop;

    assign o_en   = (r_cnt != 2'd2) || i_ready;
    assign n_push = i_vld && o_en;
    assign n_pop  = (r_cnt != 2'd0) && i_ready;
    assign o_vld  = (r_cnt != 2'd0);
    assign o_data = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + 2'(n_push) - 2'(n_pop);
            if (n_push) r_wr <= ~r_wr;
            if (n_pop)  r_rd <= ~r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

### src/fractal_value_noise_3d.sv
// Each octave cell is a fully pipelined stage row; the output buffer is registered.
// Throughput: one point per cycle unless the buffer is full and the sink stalls.
// The output buffer holds two results, so a stalled sink stops input only when full.
// Reset (synchronous, active low) clears valid flags and buffer pointers only.
// ----------------------------------------------------------------------------
// fractal_value_noise_3d
// Chain of octave cells summing 3D value noise into a saturating Q1.16 result.
// ----------------------------------------------------------------------------
module fractal_value_noise_3d (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fvn_in_if.sink     i_pt,
    fvn_out_if.source  o_noise
);
    import fvn_pkg::*;

    logic              w_en;
    logic [OCTAVES:0]  w_vld;
    t_side             w_side [OCTAVES+1];

    always_comb begin
        w_side[0].crd[0] = CRD_W'(signed'(i_pt.coord_x));
        w_side[0].crd[1] = CRD_W'(signed'(i_pt.coord_y));
        w_side[0].crd[2] = CRD_W'(signed'(i_pt.coord_z));
        w_side[0].sum    = '0;
    end

    assign w_vld[0]   = i_pt.valid;
    assign i_pt.ready = w_en;

    for (genvar g = 0; g < OCTAVES; g++) begin : g_cell
        fvn_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_octave (OCT_W'(g)),
            .i_vld    (w_vld[g]),
            .i_side   (w_side[g]),
            .o_vld    (w_vld[g+1]),
            .o_side   (w_side[g+1])
        );
    end

    fvn_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[OCTAVES]),
        .i_data  (w_side[OCTAVES].sum),
        .o_en    (w_en),
        .o_vld   (o_noise.valid),
        .i_ready (o_noise.ready),
        .o_data  (o_noise.noise_sum)
    );

endmodule
